// ===== rtl/cee_pkg.sv =====
package cee_pkg;

  localparam logic [7:0] ESCAPE_RESET = 8'h5c;  // backslash
  localparam logic [7:0] CHAR_X       = 8'h78;  // 'x'

  typedef enum logic [1:0] {
    MODE_TEXT   = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX_HI = 2'd2,
    MODE_HEX_LO = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
    logic       error;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  // invalid digits count as zero
  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.bad   = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h61:   r = 8'h07;  // a
      8'h62:   r = 8'h08;  // b
      8'h66:   r = 8'h0c;  // f
      8'h6e:   r = 8'h0a;  // n
      8'h72:   r = 8'h0d;  // r
      8'h74:   r = 8'h09;  // t
      8'h76:   r = 8'h0b;  // v
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/c_escape_expander.sv =====
// c string escape expander: takes one character per transfer and expands c escape
// sequences (simple escapes, two-digit hex escapes after 'x'), giving zero or one
// result per input character; the introducer byte is the write data of the cfg
// channel and resets to backslash. the mode register and the decode logic finish
// each character in the cycle it is accepted, and the result register holds the
// outcome, so a new character is taken every cycle unless a finished result is
// waiting while out_stall is high. a bad hex digit counts as zero and sets error;
// an escape cut by in_last yields a result with has_byte low, out_last and error
// high. cfg writes are taken at once and must only come while the block is idle.
module c_escape_expander (
  input  logic       clk,
  input  logic       rst,
  // input characters
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  // results
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last,
  output logic       error,
  // introducer register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0]       escape_char;
  logic             accept;
  logic             result_ok;
  logic             busy;
  cee_pkg::result_t result;
  cee_pkg::result_t held;

  // register writes never wait
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_char <= cee_pkg::ESCAPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      escape_char <= cfg_data;
    end
  end

  // only a full result register facing a stalled sink holds back input
  assign in_stall = busy;
  assign accept   = in_valid & ~in_stall;

  // mode state and per-character decode
  cee_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .escape_char (escape_char),
    .result_ok   (result_ok),
    .result      (result)
  );

  // result register, loaded only by characters that give a result
  cee_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept & result_ok),
    .din       (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (busy),
    .dout      (held)
  );

  assign out_byte = held.out_byte;
  assign has_byte = held.has_byte;
  assign out_last = held.out_last;
  assign error    = held.error;

endmodule

// ===== rtl/cee_decode.sv =====
module cee_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic [7:0]        escape_char,
  output logic              result_ok,
  output cee_pkg::result_t  result
);

  cee_pkg::mode_t mode, mode_next;
  logic [3:0]     high_nibble, high_nibble_next;
  logic           bad_digit, bad_digit_next;
  cee_pkg::hex_t  hex;

  assign hex = cee_pkg::hex_digit(in_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= cee_pkg::MODE_TEXT;
      high_nibble <= 4'd0;
      bad_digit   <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      high_nibble <= high_nibble_next;
      bad_digit   <= bad_digit_next;
    end
  end

  // next state
  always_comb begin
    mode_next        = cee_pkg::MODE_TEXT;
    high_nibble_next = 4'd0;
    bad_digit_next   = 1'b0;
    unique case (mode)
      cee_pkg::MODE_TEXT: begin
        if (in_byte == escape_char && !in_last) mode_next = cee_pkg::MODE_ESC;
      end
      cee_pkg::MODE_ESC: begin
        if (in_byte == cee_pkg::CHAR_X && !in_last) mode_next = cee_pkg::MODE_HEX_HI;
      end
      cee_pkg::MODE_HEX_HI: begin
        if (!in_last) begin
          mode_next        = cee_pkg::MODE_HEX_LO;
          high_nibble_next = hex.value;
          bad_digit_next   = hex.bad;
        end
      end
      cee_pkg::MODE_HEX_LO: begin
        mode_next = cee_pkg::MODE_TEXT;
      end
      default: mode_next = cee_pkg::MODE_TEXT;
    endcase
  end

  // outputs; the cut-short result is the default shape
  always_comb begin
    result_ok       = 1'b0;
    result.out_byte = 8'd0;
    result.has_byte = 1'b0;
    result.out_last = 1'b1;
    result.error    = 1'b1;
    unique case (mode)
      cee_pkg::MODE_TEXT: begin
        if (in_byte == escape_char) begin
          result_ok = in_last;
        end else begin
          result_ok       = 1'b1;
          result.out_byte = in_byte;
          result.has_byte = 1'b1;
          result.out_last = in_last;
          result.error    = 1'b0;
        end
      end
      cee_pkg::MODE_ESC: begin
        if (in_byte == cee_pkg::CHAR_X) begin
          result_ok = in_last;
        end else begin
          result_ok       = 1'b1;
          result.out_byte = cee_pkg::simple_escape(in_byte);
          result.has_byte = 1'b1;
          result.out_last = in_last;
          result.error    = 1'b0;
        end
      end
      cee_pkg::MODE_HEX_HI: begin
        result_ok = in_last;
      end
      cee_pkg::MODE_HEX_LO: begin
        result_ok       = 1'b1;
        result.out_byte = {high_nibble, hex.value};
        result.has_byte = 1'b1;
        result.out_last = in_last;
        result.error    = hex.bad | bad_digit;
      end
      default: result_ok = 1'b0;
    endcase
  end

endmodule

// ===== rtl/cee_out_reg.sv =====
module cee_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cee_pkg::result_t  din,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              busy,
  output cee_pkg::result_t  dout
);

  logic full;

  assign out_valid = full;
  assign busy      = full & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (!out_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

// ===== rtl/cee_checker.sv =====
module cee_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       out_last,
  input logic       error,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [7:0] cfg_data
);

  // input waits only behind a result that is itself waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  // an empty result is always a cut-short string end
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> (out_last && error && out_byte == 8'd0))
    else $error("empty result not flagged as cut short");

  // a new result needs an input transfer the cycle before
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an input transfer");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(has_byte)
                                  && $stable(out_last) && $stable(error)))
    else $error("stalled result changed");

endmodule

bind c_escape_expander cee_checker u_cee_checker (.*);

// ===== sim/c_escape_expander_tb.sv =====
module c_escape_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one character of a source literal as it goes over the input channel
  typedef struct {
    logic [7:0] chr;
    logic       last;
  } char_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       out_last;
  logic       error;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  c_escape_expander uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .out_last  (out_last),
    .error     (error),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // characters waiting to be sent, and decoded characters still owed by the block
  char_item_t          char_q[$];
  cee_pkg::result_t    decoded_q[$];

  int         failures = 0;
  logic       in_taken = 1'b0;   // input transfer happened at the last rising edge
  int         send_gap = 0;
  int         stall_left = 0;
  int         idle_pct = 10;     // percent chance that an idle or stall burst starts
  bit         quiet = 1'b0;      // no idling at all in the closing phase
  int         phase_count = 0;   // characters queued in the current phase
  logic [7:0] phase_esc = cee_pkg::ESCAPE_RESET;  // introducer the generator builds escapes with

  // decoder shadow: introducer register and sequence state
  logic [7:0]     esc_char = cee_pkg::ESCAPE_RESET;
  cee_pkg::mode_t dec_mode = cee_pkg::MODE_TEXT;
  logic [3:0]     dec_nibble = 4'd0;
  logic           dec_bad = 1'b0;

  // {bad, value}; anything that is not a hex digit counts as zero
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'b1_0000;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    case (c)
      "a":     return 8'h07;
      "b":     return 8'h08;
      "f":     return 8'h0c;
      "n":     return 8'h0a;
      "r":     return 8'h0d;
      "t":     return 8'h09;
      "v":     return 8'h0b;
      default: return c;
    endcase
  endfunction

  // advances the shadow decoder by one character; returns 1 when a result is due
  function automatic bit decode_char(input logic [7:0] c, input logic last,
                                     output cee_pkg::result_t res);
    logic [4:0] hv;
    logic       cut;
    res = '0;
    cut = 1'b0;
    hv = hex_value(c);
    case (dec_mode)
      cee_pkg::MODE_TEXT: begin
        if (c == esc_char) begin
          if (last) cut = 1'b1;
          else dec_mode = cee_pkg::MODE_ESC;
        end else begin
          res = '{out_byte: c, has_byte: 1'b1, out_last: last, error: 1'b0};
          return 1'b1;
        end
      end
      cee_pkg::MODE_ESC: begin
        if (c == cee_pkg::CHAR_X) begin
          if (last) cut = 1'b1;
          else dec_mode = cee_pkg::MODE_HEX_HI;
        end else begin
          // includes a second introducer, which maps to itself
          dec_mode = cee_pkg::MODE_TEXT;
          res = '{out_byte: escape_map(c), has_byte: 1'b1, out_last: last,
                  error: 1'b0};
          return 1'b1;
        end
      end
      cee_pkg::MODE_HEX_HI: begin
        if (last) cut = 1'b1;
        else begin
          dec_nibble = hv[3:0];
          dec_bad = hv[4];
          dec_mode = cee_pkg::MODE_HEX_LO;
        end
      end
      default: begin
        res = '{out_byte: {dec_nibble, hv[3:0]}, has_byte: 1'b1, out_last: last,
                error: hv[4] | dec_bad};
        dec_mode = cee_pkg::MODE_TEXT;
        dec_nibble = 4'd0;
        dec_bad = 1'b0;
        return 1'b1;
      end
    endcase
    if (cut) begin
      // escape cut by end of string: dropped, flagged, back to plain text
      dec_mode = cee_pkg::MODE_TEXT;
      dec_nibble = 4'd0;
      dec_bad = 1'b0;
      res = '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b1, error: 1'b1};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // sender: a new character goes out only once the current one has been taken
  always @(negedge clk) begin : sender
    char_item_t it;
    if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!rst && char_q.size() > 0) begin
        it = char_q.pop_front();
        in_valid <= 1'b1;
        in_byte <= it.chr;
        in_last <= it.last;
        // idle burst after this transfer
        if (!quiet && $urandom_range(0, 99) < idle_pct) send_gap <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts on the result channel
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // everything that happens at a rising edge: register write, input transfer, result check
  always @(posedge clk) begin : monitor
    cee_pkg::result_t want;
    cee_pkg::result_t got;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (cfg_valid && cfg_ready) esc_char = cfg_data;
      if (in_valid && !in_stall) begin
        if (decode_char(in_byte, in_last, want)) decoded_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{out_byte: out_byte, has_byte: has_byte, out_last: out_last, error: error};
        if (decoded_q.size() == 0) begin
          $error("unexpected result transfer: out_byte %h has_byte %b out_last %b error %b",
                 got.out_byte, got.has_byte, got.out_last, got.error);
          failures++;
        end else begin
          want = decoded_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
            failures++;
          end
          if (got.has_byte !== want.has_byte) begin
            $error("has_byte: expected %b, actual %b", want.has_byte, got.has_byte);
            failures++;
          end
          if (got.out_last !== want.out_last) begin
            $error("out_last: expected %b, actual %b", want.out_last, got.out_last);
            failures++;
          end
          if (got.error !== want.error) begin
            $error("error: expected %b, actual %b", want.error, got.error);
            failures++;
          end
        end
      end
    end
  end

  task automatic put_char(input logic [7:0] c, input logic last);
    char_item_t it;
    it.chr = c;
    it.last = last;
    char_q.push_back(it);
    phase_count++;
  endtask

  function automatic logic [7:0] pick_hex_digit();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    case ($urandom_range(0, 11))
      0:       return 8'h27;  // single quote
      1:       return 8'h22;  // double quote
      2:       return "?";
      3:       return 8'h5c;  // backslash
      4:       return "a";
      5:       return "b";
      6:       return "f";
      7:       return "n";
      8:       return "r";
      9:       return "t";
      10:      return "v";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one random literal: mostly well-formed escapes, some noise, some cut short at the end
  task automatic put_literal();
    logic [7:0] piece[4];
    int         pieces;
    int         len;
    int         r;
    pieces = $urandom_range(1, 10);
    for (int p = 0; p < pieces; p++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        piece[0] = 8'($urandom_range(0, 255));
        len = 1;
      end else if (r < 65) begin
        piece[0] = phase_esc;
        piece[1] = pick_escape_letter();
        len = 2;
      end else if (r < 90) begin
        piece[0] = phase_esc;
        piece[1] = cee_pkg::CHAR_X;
        piece[2] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : pick_hex_digit();
        piece[3] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : pick_hex_digit();
        len = 4;
      end else begin
        piece[0] = phase_esc;
        piece[1] = 8'($urandom_range(0, 255));
        len = 2;
      end
      // broken literal: the string ends inside its last escape
      if (p == pieces - 1 && len > 1 && $urandom_range(0, 7) == 0)
        len = $urandom_range(1, len - 1);
      for (int k = 0; k < len; k++)
        put_char(piece[k], (p == pieces - 1 && k == len - 1) ||
                           ($urandom_range(0, 99) < 2));
    end
  endtask

  // waits until every queued character is taken and every result is back
  task automatic wait_drained();
    while (char_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    // a character that makes no result may still be in the block
    repeat (4) @(posedge clk);
  endtask

  task automatic write_escape(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    phase_esc = value;
  endtask

  initial begin : stimulus
    logic [7:0] settings[6];
    settings[0] = cee_pkg::ESCAPE_RESET;
    settings[1] = 8'h00;
    settings[2] = 8'hff;
    settings[3] = 8'h27;
    settings[4] = 8'($urandom_range(0, 255));
    settings[5] = cee_pkg::ESCAPE_RESET;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, each kind of sequence, the cut and bad-digit cases
    put_char(8'h00, 1'b0);
    put_char(8'hff, 1'b1);
    put_char(8'h5c, 1'b0); put_char("n", 1'b0);          // simple escape
    put_char(8'h5c, 1'b0); put_char("q", 1'b0);          // unknown letter passes
    put_char(8'h5c, 1'b0); put_char(8'h5c, 1'b1);        // introducer twice, ends string
    put_char(8'h5c, 1'b0); put_char(cee_pkg::CHAR_X, 1'b0);
    put_char("4", 1'b0); put_char("F", 1'b0);            // hex escape
    put_char(8'h5c, 1'b0); put_char(cee_pkg::CHAR_X, 1'b0);
    put_char("g", 1'b0); put_char("7", 1'b1);            // bad high digit
    put_char(8'h5c, 1'b0); put_char(cee_pkg::CHAR_X, 1'b0);
    put_char("3", 1'b0); put_char("z", 1'b0);            // bad low digit
    put_char(8'h5c, 1'b1);                               // cut on introducer
    put_char(8'h5c, 1'b0); put_char(cee_pkg::CHAR_X, 1'b1);  // cut on 'x'
    put_char(8'h5c, 1'b0); put_char(cee_pkg::CHAR_X, 1'b0);
    put_char("A", 1'b1);                                 // cut on first digit

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_escape(settings[ph]);
      end
      idle_pct = (ph == 2) ? 0 : $urandom_range(5, 25);
      quiet = (ph == 5);
      while (phase_count < 185) put_literal();
      phase_count = 0;
    end

    wait_drained();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== c_escape_expander.f =====
rtl/cee_pkg.sv
rtl/cee_decode.sv
rtl/cee_out_reg.sv
rtl/c_escape_expander.sv
rtl/cee_checker.sv
sim/c_escape_expander_tb.sv
